### src/sorted_table_binary_search_macros.svh
// assertion macros for the sorted table search block
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// property checked on every clock edge outside reset
`define STBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/stbs_pkg.sv
package stbs_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int POS_W       = 8;
  localparam int RIDX_W      = 7;
  // wide enough for position and count plus one
  localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  // signed search bounds, high may reach -1 and low may reach 128
  localparam int SIDX_W      = RIDX_W + 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_POS   = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_KEY_WR,
    ST_PROBE,
    ST_COMPARE,
    ST_FINISH
  } state_t;

endpackage

### src/stbs_ram.sv
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/sorted_table_binary_search.sv
// insert: entries from the position up move one place, one entry moved per cycle by
//   the table port pair, then the key is written; a rejected insert or empty range
//   goes straight to the result; a search alternates probe and compare until a match
//   or low passes high. One item at a time, next accept in the cycle after out_load
// reset: rst (synchronous) clears the fill count, sequencer and output valid;
//   table contents are not cleared and there is no clearing pass
`include "sorted_table_binary_search_macros.svh"

module sorted_table_binary_search import stbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     operation,
  input  logic [POS_W-1:0]         position,
  input  logic signed [KEY_W-1:0]  key,
  input  logic [RIDX_W-1:0]        low_index,
  input  logic [RIDX_W-1:0]        high_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic                     found,
  output logic [RIDX_W-1:0]        match_index
);

  // sequencer
  state_t state, state_next;

  // stored state
  logic [CNT_W-1:0] entry_count;

  // item registers
  logic [KEY_W-1:0]         op_key;
  logic [POS_W-1:0]         ins_pos;
  logic [IDX_W-1:0]         shift_addr;   // write target of the next move
  logic [IDX_W-1:0]         wr_addr;      // write target of the move in flight
  logic                     mv_pend;      // a read for a move was issued last cycle
  logic signed [SIDX_W-1:0] lo;
  logic signed [SIDX_W-1:0] hi;
  logic [RIDX_W-1:0]        probe_idx;
  logic                     probe_in_tbl;

  // result being built, and the output register
  status_t           res_status;
  logic              res_found;
  logic [RIDX_W-1:0] res_index;
  status_t           out_status;
  logic              out_found;
  logic [RIDX_W-1:0] out_index;

  // memory port
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  logic in_accept;
  logic out_free;
  logic out_load;

  // insert checks, taken at accept
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             bad_pos;
  logic             is_full;
  logic             range_empty;

  // shift and search helpers
  logic              move_left;
  logic [SIDX_W-1:0] bound_sum;
  logic [RIDX_W-1:0] mid;
  logic              mid_in_tbl;
  logic              search_done;
  logic [KEY_W-1:0]  probe_key;
  logic              key_eq;
  logic              key_lt;

  stbs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // position must lie in 1 .. count + 1, checked before capacity
  assign pos_ext     = CMP_W'(position);
  assign cnt_ext     = CMP_W'(entry_count);
  assign bad_pos     = (position == '0) || (pos_ext > (cnt_ext + CMP_W'(1)));
  assign is_full     = entry_count >= CNT_W'(TABLE_DEPTH);
  assign range_empty = low_index > high_index;

  // moves remain while the target index is at or above the insert position
  assign move_left = CMP_W'(shift_addr) >= CMP_W'(ins_pos);

  // bounds are non-negative whenever a probe is issued, so halving is a shift
  assign bound_sum   = lo + hi;
  assign mid         = bound_sum[RIDX_W:1];
  assign mid_in_tbl  = 32'(mid) < 32'(TABLE_DEPTH);
  assign search_done = lo > hi;

  // comparator: an index beyond the table reads as zero
  assign probe_key = probe_in_tbl ? ram_rdata : '0;
  assign key_eq    = probe_key == op_key;
  assign key_lt    = $signed(probe_key) < $signed(op_key);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (operation == OP_FIND) begin
            state_next = range_empty ? ST_FINISH : ST_PROBE;
          end else begin
            state_next = (bad_pos || is_full) ? ST_FINISH : ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        // the last pending move write lands in this cycle
        if (!move_left) begin
          state_next = ST_KEY_WR;
        end
      end
      ST_KEY_WR: begin
        state_next = ST_FINISH;
      end
      ST_PROBE: begin
        state_next = search_done ? ST_FINISH : ST_COMPARE;
      end
      ST_COMPARE: begin
        state_next = key_eq ? ST_FINISH : ST_PROBE;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = ram_rdata;
    ram_raddr = shift_addr - IDX_W'(1);
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SHIFT: begin
        // read entry k-1 while writing the entry read last cycle one place up
        ram_raddr = shift_addr - IDX_W'(1);
        ram_we    = mv_pend;
        ram_waddr = wr_addr;
        ram_wdata = ram_rdata;
      end
      ST_KEY_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(ins_pos - POS_W'(1));
        ram_wdata = op_key;
      end
      ST_PROBE: begin
        ram_raddr = IDX_W'(mid);
      end
      ST_COMPARE: begin
        ram_we = 1'b0;
      end
      ST_FINISH: begin
        out_load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      mv_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_KEY_WR) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      if (in_accept) begin
        mv_pend <= 1'b0;
      end else if (state == ST_SHIFT) begin
        mv_pend <= move_left;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_key     <= key;
      ins_pos    <= position;
      shift_addr <= IDX_W'(entry_count);
      lo         <= SIDX_W'(low_index);
      hi         <= SIDX_W'(high_index);
      res_found  <= 1'b0;
      res_index  <= '0;
      if (operation == OP_FIND) begin
        res_status <= STATUS_NOT_FOUND;
      end else if (bad_pos) begin
        res_status <= STATUS_BAD_POS;
      end else if (is_full) begin
        res_status <= STATUS_FULL;
      end else begin
        res_status <= STATUS_OK;
      end
    end
    if (state == ST_SHIFT && move_left) begin
      wr_addr    <= shift_addr;
      shift_addr <= shift_addr - IDX_W'(1);
    end
    if (state == ST_PROBE) begin
      probe_idx    <= mid;
      probe_in_tbl <= mid_in_tbl;
    end
    if (state == ST_COMPARE) begin
      if (key_eq) begin
        res_status <= STATUS_OK;
        res_found  <= 1'b1;
        res_index  <= probe_idx;
      end else if (key_lt) begin
        lo <= SIDX_W'(probe_idx) + SIDX_W'(1);
      end else begin
        hi <= SIDX_W'(probe_idx) - SIDX_W'(1);
      end
    end
    if (out_load) begin
      out_status <= res_status;
      out_found  <= res_found;
      out_index  <= res_index;
    end
  end

  assign status      = out_status;
  assign found       = out_found;
  assign match_index = out_index;

  // checks
  `STBS_ASSERT(a_count_bound, entry_count <= CNT_W'(TABLE_DEPTH), "fill count above depth")
  `STBS_ASSERT_NEXT(a_busy_after_accept, in_accept, !in_ready, "ready right after accept")
  `STBS_ASSERT(a_no_write_in_search, !((state == ST_PROBE || state == ST_COMPARE) && ram_we),
    "table written during search")
  `STBS_ASSERT(a_found_ok, !(out_valid && found) || (status == STATUS_OK),
    "found flag with bad status")

endmodule

### tb/sorted_table_binary_search_tb.sv
`timescale 1ns / 1ps

module sorted_table_binary_search_tb;
  import stbs_pkg::*;

  typedef struct {
    status_t             st;
    logic                fnd;
    logic [RIDX_W-1:0]   idx;
  } result_t;

  // one item as offered on the input channel, plus an optional typed-in answer
  typedef struct {
    logic                     op;
    logic [POS_W-1:0]         pos;
    logic signed [KEY_W-1:0]  key;
    logic [RIDX_W-1:0]        lo;
    logic [RIDX_W-1:0]        hi;
    bit                       typed;
    result_t                  want;
  } req_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    operation = OP_INSERT;
  logic [POS_W-1:0]        position = '0;
  logic signed [KEY_W-1:0] key = '0;
  logic [RIDX_W-1:0]       low_index = '0;
  logic [RIDX_W-1:0]       high_index = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              status;
  logic                    found;
  logic [RIDX_W-1:0]       match_index;

  sorted_table_binary_search dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .position    (position),
    .key         (key),
    .low_index   (low_index),
    .high_index  (high_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found       (found),
    .match_index (match_index)
  );

  always #10 clk = ~clk;

  // shadow copy of the key table and its fill count
  logic signed [KEY_W-1:0] keys [TABLE_DEPTH];
  int                      fill = 0;

  result_t pending_results [$];
  req_t    directed_rows [$];
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  // insert shifts the upper entries up by one; find is an inclusive binary search
  task automatic apply_table_op(input req_t rq, output result_t res);
    int lo_b;
    int hi_b;
    int mid;
    res.st  = STATUS_OK;
    res.fnd = 1'b0;
    res.idx = '0;
    if (rq.op == OP_INSERT) begin
      // bad position is checked before capacity
      if (rq.pos == 0 || int'(rq.pos) > fill + 1) begin
        res.st = STATUS_BAD_POS;
      end else if (fill >= TABLE_DEPTH) begin
        res.st = STATUS_FULL;
      end else begin
        for (int k = fill; k >= int'(rq.pos); k--) keys[k] = keys[k-1];
        keys[int'(rq.pos) - 1] = rq.key;
        fill++;
      end
    end else begin
      res.st = STATUS_NOT_FOUND;
      lo_b = rq.lo;
      hi_b = rq.hi;
      // stops on a match or as soon as low passes high, an inverted range probes nothing
      while (lo_b <= hi_b && !res.fnd) begin
        mid = (lo_b + hi_b) / 2;
        if (keys[mid] == rq.key) begin
          res.st  = STATUS_OK;
          res.fnd = 1'b1;
          res.idx = RIDX_W'(mid);
        end else if (keys[mid] < rq.key) begin
          lo_b = mid + 1;
        end else begin
          hi_b = mid - 1;
        end
      end
    end
  endtask

  function automatic req_t row(logic op, int pos, logic [KEY_W-1:0] k, int lo, int hi,
                               int typed = 0, status_t st = STATUS_OK,
                               int fnd = 0, int idx = 0);
    req_t r;
    r.op       = op;
    r.pos      = POS_W'(pos);
    r.key      = k;
    r.lo       = RIDX_W'(lo);
    r.hi       = RIDX_W'(hi);
    r.typed    = (typed != 0);
    r.want.st  = st;
    r.want.fnd = (fnd != 0);
    r.want.idx = RIDX_W'(idx);
    return r;
  endfunction

  // random item shaped by the current table: mostly sorted inserts and
  // searches over written entries, some bad positions and out-of-order inserts
  function automatic req_t random_request();
    req_t r;
    int   sel;
    int   p;
    r.op    = OP_FIND;
    r.pos   = POS_W'($urandom);
    r.key   = $urandom;
    r.lo    = RIDX_W'($urandom);
    r.hi    = RIDX_W'($urandom);
    r.typed = 1'b0;
    r.want  = '{STATUS_OK, 1'b0, '0};
    sel = $urandom_range(0, 99);
    if (sel < ((fill < TABLE_DEPTH) ? 40 : 15)) begin
      r.op = OP_INSERT;
      sel = $urandom_range(0, 99);
      // clustered small keys give duplicates, extremes hit the sign bit
      if (sel < 20) r.key = $signed($urandom_range(0, 40)) - 20;
      else if (sel < 25) r.key = {1'b1, {(KEY_W-1){1'b0}}};
      else if (sel < 30) r.key = {1'b0, {(KEY_W-1){1'b1}}};
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        // upper-bound position keeps the table sorted
        p = 0;
        while (p < fill && keys[p] <= r.key) p++;
        r.pos = POS_W'(p + 1);
      end else if (sel < 85) begin
        r.pos = POS_W'($urandom_range(1, fill + 1));
      end else if (sel < 92) begin
        r.pos = '0;
      end else begin
        r.pos = POS_W'($urandom_range(fill + 2, 255));
      end
    end else begin
      sel = $urandom_range(0, 99);
      if (fill > 0 && sel < 50) r.key = keys[$urandom_range(0, fill - 1)];
      else if (fill > 0 && sel < 70) r.key = keys[$urandom_range(0, fill - 1)] +
                                             ($urandom_range(0, 1) ? 1 : -1);
      sel = $urandom_range(0, 99);
      if (fill == 0 || sel < 10) begin
        // inverted range, no entry is read
        r.lo = RIDX_W'($urandom_range(1, 127));
        r.hi = RIDX_W'($urandom_range(0, int'(r.lo) - 1));
      end else if (sel < 75) begin
        r.lo = '0;
        r.hi = RIDX_W'(fill - 1);
      end else begin
        r.hi = RIDX_W'($urandom_range(0, fill - 1));
        r.lo = RIDX_W'($urandom_range(0, int'(r.hi)));
      end
    end
    return r;
  endfunction

  // offer one item, hold it until accepted, then record what it should produce
  task automatic send_item(input req_t rq);
    result_t res;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    operation  <= rq.op;
    position   <= rq.pos;
    key        <= rq.key;
    low_index  <= rq.lo;
    high_index <= rq.hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_table_op(rq, res);
    pending_results.push_back(rq.typed ? rq.want : res);
  endtask

  // result side: random stalls, each accepted item checked against the oldest expectation
  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result status %0d found %0b index %0d",
                   $time, status, found, match_index);
          errors++;
        end else begin
          exp_r = pending_results.pop_front();
          if (status !== exp_r.st || found !== exp_r.fnd || match_index !== exp_r.idx) begin
            $display("%0t: mismatch, expected status %0d found %0b index %0d, got %0d %0b %0d",
                     $time, exp_r.st, exp_r.fnd, exp_r.idx, status, found, match_index);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    // directed rows, starting from an empty table
    directed_rows.push_back(row(OP_FIND, 0, 32'd0, 1, 0, 1, STATUS_NOT_FOUND));
    directed_rows.push_back(row(OP_INSERT, 0, 32'd5, 127, 127, 1, STATUS_BAD_POS));
    directed_rows.push_back(row(OP_INSERT, 2, 32'd5, 0, 0, 1, STATUS_BAD_POS));
    directed_rows.push_back(row(OP_INSERT, 255, 32'd5, 127, 0, 1, STATUS_BAD_POS));
    directed_rows.push_back(row(OP_INSERT, 1, 32'h7fffffff, 127, 127, 1, STATUS_OK));
    directed_rows.push_back(row(OP_INSERT, 1, 32'h80000000, 0, 127, 1, STATUS_OK));
    directed_rows.push_back(row(OP_FIND, 255, 32'h80000000, 0, 1, 1, STATUS_OK, 1, 0));
    directed_rows.push_back(row(OP_FIND, 0, 32'h7fffffff, 0, 1, 1, STATUS_OK, 1, 1));
    directed_rows.push_back(row(OP_FIND, 0, 32'd0, 0, 1, 1, STATUS_NOT_FOUND));
    directed_rows.push_back(row(OP_FIND, 0, 32'h7fffffff, 127, 0, 1, STATUS_NOT_FOUND));
    directed_rows.push_back(row(OP_INSERT, 2, 32'd0, 0, 0));
    directed_rows.push_back(row(OP_INSERT, 4, 32'h7fffffff, 0, 0));
    directed_rows.push_back(row(OP_INSERT, 2, 32'hffffffff, 5, 9));
    directed_rows.push_back(row(OP_FIND, 0, 32'hffffffff, 0, 4));
    directed_rows.push_back(row(OP_FIND, 0, 32'd0, 0, 4));
    directed_rows.push_back(row(OP_FIND, 0, 32'h7fffffff, 0, 4));
    directed_rows.push_back(row(OP_FIND, 0, 32'h80000000, 1, 4));
    directed_rows.push_back(row(OP_FIND, 0, 32'd0, 2, 2));
    directed_rows.push_back(row(OP_INSERT, 7, 32'd1, 0, 0, 1, STATUS_BAD_POS));
    directed_rows.push_back(row(OP_FIND, 0, 32'd1, 0, 4));
    directed_rows.push_back(row(OP_INSERT, 6, 32'h7fffffff, 0, 0, 1, STATUS_OK));
    directed_rows.push_back(row(OP_FIND, 0, 32'h80000000, 0, 0, 1, STATUS_OK, 1, 0));
    directed_rows.push_back(row(OP_FIND, 255, 32'h12345678, 0, 5));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // three idle profiles: slow receiver, slow sender, then full rate
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 83 : 0;
      recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 34 : 0;
      repeat (626) send_item(random_request());
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // let a stray late result show up
    repeat (300) @(posedge clk);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
